// ===== rtl/bal_pkg.sv =====
// bal_pkg: shared types and constants of the bounded array list.
// Used by bal_engine and bounded_array_list_core; depends on nothing.
`default_nettype none

package bal_pkg;

  localparam int DEF_MAX_ENTRIES  = 64;
  localparam int DEF_HANDLE_WIDTH = 32;

  localparam int OP_W     = 2;
  localparam int VALUE_W  = 32;
  localparam int INDEX_W  = 6;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 7;
  localparam int CAP_W    = 7;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH     = 2'd0,
    OP_POP_LAST = 2'd1,
    OP_POP_AT   = 2'd2,
    OP_REMOVE   = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_RANGE    = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  typedef struct packed {
    op_t                op;
    logic [VALUE_W-1:0] value;
    logic [INDEX_W-1:0] index;
  } req_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value_out;
    status_t            status;
    logic [COUNT_W-1:0] count;
    logic               is_empty;
    logic               is_full;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/bounded_array_list_core.sv =====
// bounded_array_list_core: top level with capacity register and output register.
// Depends on bal_pkg and bal_engine.
//
//   channel  ports                                      transfer when
//   input    in_valid in_stall in_op in_value in_index   in_valid & !in_stall
//   result   out_valid out_stall out_value_out ...       out_valid & !out_stall
//   config   cfg_we cfg_wdata                            cfg_we
//
// Push, and any request that fails at once, goes straight to the result; pop last
// reads the last entry. Pop at index reads the entry, then shifts the later entries
// down; remove by value searches from entry 0 for the first match, then shifts likewise.
// The entry memory (one read, one write port) moves one entry a cycle while shifting.
// Synchronous reset empties the list and sets capacity to 64; no clearing pass.
// A new request is taken while an earlier result waits under out_stall.
`default_nettype none

module bounded_array_list_core #(
  parameter int MAX_ENTRIES  = bal_pkg::DEF_MAX_ENTRIES,
  parameter int HANDLE_WIDTH = bal_pkg::DEF_HANDLE_WIDTH
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [bal_pkg::OP_W-1:0]      in_op,
  input  wire logic [bal_pkg::VALUE_W-1:0]   in_value,
  input  wire logic [bal_pkg::INDEX_W-1:0]   in_index,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [bal_pkg::VALUE_W-1:0]        out_value_out,
  output logic [bal_pkg::STATUS_W-1:0]       out_status,
  output logic [bal_pkg::COUNT_W-1:0]        out_count,
  output logic                               out_is_empty,
  output logic                               out_is_full,
  input  wire logic                          cfg_we,
  input  wire logic [bal_pkg::CAP_W-1:0]     cfg_wdata
);

  localparam int CW = ($clog2(MAX_ENTRIES + 1) > bal_pkg::CAP_W) ?
                      $clog2(MAX_ENTRIES + 1) : bal_pkg::CAP_W;

  logic [bal_pkg::CAP_W-1:0] cap_r, cap_nxt;
  logic [CW-1:0]             cap_w;
  logic [CW-1:0]             eff_cap;
  bal_pkg::req_t             req;
  bal_pkg::res_t             res;
  bal_pkg::res_t             out_r, out_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic                      res_valid;
  logic                      res_take;

  assign cap_w   = CW'(cap_r);
  assign eff_cap = (cap_r == '0) ? CW'(1) :
                   (cap_w > CW'(MAX_ENTRIES)) ? CW'(MAX_ENTRIES) : cap_w;

  assign req.op    = bal_pkg::op_t'(in_op);
  assign req.value = in_value;
  assign req.index = in_index;

  bal_engine #(
    .MAX_ENTRIES  (MAX_ENTRIES),
    .HANDLE_WIDTH (HANDLE_WIDTH),
    .CW           (CW)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_valid),
    .req       (req),
    .req_stall (in_stall),
    .eff_cap   (eff_cap),
    .res_valid (res_valid),
    .res       (res),
    .res_take  (res_take)
  );

  assign res_take = res_valid && (!out_valid_r || !out_stall);

  always_comb begin
    cap_nxt       = cfg_we ? cfg_wdata : cap_r;
    out_nxt       = res_take ? res : out_r;
    out_valid_nxt = out_valid_r;
    if (res_take) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= bal_pkg::CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      cap_r       <= cap_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_r <= out_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_value_out = out_r.value_out;
  assign out_status    = out_r.status;
  assign out_count     = out_r.count;
  assign out_is_empty  = out_r.is_empty;
  assign out_is_full   = out_r.is_full;

endmodule

`default_nettype wire

// ===== rtl/bal_engine.sv =====
// bal_engine: entry memory, occupancy and the sequencer for push, pop, search and shift.
// Depends on bal_pkg.
`default_nettype none

module bal_engine #(
  parameter int MAX_ENTRIES  = bal_pkg::DEF_MAX_ENTRIES,
  parameter int HANDLE_WIDTH = bal_pkg::DEF_HANDLE_WIDTH,
  parameter int CW = ($clog2(MAX_ENTRIES + 1) > bal_pkg::CAP_W) ?
                     $clog2(MAX_ENTRIES + 1) : bal_pkg::CAP_W
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          req_valid,
  input  wire bal_pkg::req_t req,
  output logic               req_stall,
  input  wire logic [CW-1:0] eff_cap,
  output logic               res_valid,
  output bal_pkg::res_t      res,
  input  wire logic          res_take
);

  localparam int OW = $clog2(MAX_ENTRIES + 1);
  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int XW = (HANDLE_WIDTH > bal_pkg::VALUE_W) ? HANDLE_WIDTH : bal_pkg::VALUE_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TAKE,
    S_SEARCH,
    S_SHIFT,
    S_DONE
  } state_t;

  state_t                  state_r, state_nxt;
  logic [OW-1:0]           occ_r, occ_nxt;
  logic [AW-1:0]           src_r, src_nxt;
  logic [AW-1:0]           end_r, end_nxt;
  logic [HANDLE_WIDTH-1:0] val_r, val_nxt;
  logic [HANDLE_WIDTH-1:0] vout_r, vout_nxt;
  bal_pkg::status_t        status_r, status_nxt;

  logic [HANDLE_WIDTH-1:0] mem [MAX_ENTRIES];
  logic [HANDLE_WIDTH-1:0] rdata;
  logic [AW-1:0]           raddr;
  logic [AW-1:0]           waddr;
  logic [HANDLE_WIDTH-1:0] wdata;
  logic                    we;

  logic [XW-1:0]           in_x;
  logic [HANDLE_WIDTH-1:0] in_h;
  logic [XW-1:0]           vout_x;
  logic [CW-1:0]           occ_w;
  logic [CW-1:0]           idx_w;
  logic [OW-1:0]           occ_m1;
  logic                    full_now;

  assign in_x     = XW'(req.value);
  assign in_h     = in_x[HANDLE_WIDTH-1:0];
  assign vout_x   = XW'(vout_r);
  assign occ_w    = CW'(occ_r);
  assign idx_w    = CW'(req.index);
  assign occ_m1   = occ_r - OW'(1);
  assign full_now = occ_w >= eff_cap;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_comb begin
    state_nxt  = state_r;
    occ_nxt    = occ_r;
    src_nxt    = src_r;
    end_nxt    = end_r;
    val_nxt    = val_r;
    vout_nxt   = vout_r;
    status_nxt = status_r;
    we         = 1'b0;
    waddr      = src_r - AW'(1);
    wdata      = rdata;
    raddr      = src_r + AW'(1);
    case (state_r)
      S_IDLE: begin
        if (req_valid) begin
          vout_nxt   = '0;
          status_nxt = bal_pkg::ST_OK;
          end_nxt    = occ_m1[AW-1:0];
          state_nxt  = S_DONE;
          if (req.op == bal_pkg::OP_PUSH) begin
            if (full_now) begin
              status_nxt = bal_pkg::ST_FULL;
            end else begin
              we      = 1'b1;
              waddr   = occ_r[AW-1:0];
              wdata   = in_h;
              occ_nxt = occ_r + OW'(1);
            end
          end else if (occ_r == '0) begin
            status_nxt = bal_pkg::ST_EMPTY;
          end else if (req.op == bal_pkg::OP_POP_LAST) begin
            raddr     = occ_m1[AW-1:0];
            src_nxt   = occ_m1[AW-1:0];
            state_nxt = S_TAKE;
          end else if (req.op == bal_pkg::OP_POP_AT) begin
            if (idx_w >= occ_w) begin
              status_nxt = bal_pkg::ST_RANGE;
            end else begin
              raddr     = idx_w[AW-1:0];
              src_nxt   = idx_w[AW-1:0];
              state_nxt = S_TAKE;
            end
          end else begin
            raddr      = '0;
            src_nxt    = '0;
            val_nxt    = in_h;
            status_nxt = bal_pkg::ST_NOTFOUND;
            state_nxt  = S_SEARCH;
          end
        end
      end
      S_TAKE: begin
        vout_nxt = rdata;
        if (src_r == end_r) begin
          occ_nxt   = occ_m1;
          state_nxt = S_DONE;
        end else begin
          src_nxt   = src_r + AW'(1);
          state_nxt = S_SHIFT;
        end
      end
      S_SEARCH: begin
        if (rdata == val_r) begin
          status_nxt = bal_pkg::ST_OK;
          if (src_r == end_r) begin
            occ_nxt   = occ_m1;
            state_nxt = S_DONE;
          end else begin
            src_nxt   = src_r + AW'(1);
            state_nxt = S_SHIFT;
          end
        end else if (src_r == end_r) begin
          state_nxt = S_DONE;
        end else begin
          src_nxt = src_r + AW'(1);
        end
      end
      S_SHIFT: begin
        we = 1'b1;
        if (src_r == end_r) begin
          occ_nxt   = occ_m1;
          state_nxt = S_DONE;
        end else begin
          src_nxt = src_r + AW'(1);
        end
      end
      S_DONE: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      occ_r   <= '0;
    end else begin
      state_r <= state_nxt;
      occ_r   <= occ_nxt;
    end
    src_r    <= src_nxt;
    end_r    <= end_nxt;
    val_r    <= val_nxt;
    vout_r   <= vout_nxt;
    status_r <= status_nxt;
  end

  assign req_stall     = (state_r != S_IDLE);
  assign res_valid     = (state_r == S_DONE);
  assign res.value_out = vout_x[bal_pkg::VALUE_W-1:0];
  assign res.status    = status_r;
  assign res.count     = occ_w[bal_pkg::COUNT_W-1:0];
  assign res.is_empty  = (occ_r == '0);
  assign res.is_full   = full_now;

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OW'(MAX_ENTRIES))
    else $error("occupancy above depth");

  a_occ_step: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(occ_r) |-> (occ_r == $past(occ_r) + OW'(1) || occ_r == $past(occ_r) - OW'(1)))
    else $error("occupancy moved by more than one");

  a_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
    (we && state_r == S_IDLE) |-> (req_valid && req.op == bal_pkg::OP_PUSH && !full_now))
    else $error("memory write in idle without push");

  a_done_release: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && res_take) |=> !req_stall)
    else $error("engine not released after result transfer");

endmodule

`default_nettype wire
